/* design/bcdep_pkg.sv */
// Shared constants and helpers for the BCD calendar to epoch seconds converter.
`default_nettype none
package bcdep_pkg;

    localparam int unsigned EPOCH_YEAR   = 1970;
    localparam int unsigned LEAP_BASE    = (EPOCH_YEAR - 1) / 4;
    localparam int unsigned DAYS_PER_YR  = 365;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned YEAR_W       = 15;
    localparam int unsigned PART_W       = 9;
    localparam int unsigned TMIN_W       = 14;
    localparam int unsigned DAYS_W       = 23;
    localparam int unsigned TOD_W        = 20;
    localparam int unsigned EPOCH_W      = 39;

    // Packed BCD byte to binary, nibbles taken at face value.
    function automatic logic [7:0] bcd_val(input logic [7:0] b);
        logic [7:0] hi;
        logic [7:0] lo;
        begin
            hi = {4'd0, b[7:4]};
            lo = {4'd0, b[3:0]};
            bcd_val = (hi << 3) + (hi << 1) + lo;
        end
    endfunction

    // Days in the months before the given one; months past December saturate.
    function automatic logic [8:0] days_before_month(input logic [7:0] mon);
        begin
            case (mon)
                8'd0:    days_before_month = 9'd0;
                8'd1:    days_before_month = 9'd0;
                8'd2:    days_before_month = 9'd31;
                8'd3:    days_before_month = 9'd59;
                8'd4:    days_before_month = 9'd90;
                8'd5:    days_before_month = 9'd120;
                8'd6:    days_before_month = 9'd151;
                8'd7:    days_before_month = 9'd181;
                8'd8:    days_before_month = 9'd212;
                8'd9:    days_before_month = 9'd243;
                8'd10:   days_before_month = 9'd273;
                8'd11:   days_before_month = 9'd304;
                default: days_before_month = 9'd334;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

/* design/bcd_date_time_to_epoch_seconds_unit.sv */
// Four-stage pipeline turning BCD time and date words into seconds since 1970.
`default_nettype none
// Takes one time/date word pair per cycle into four register stages (BCD decode
// and month lookup, prior-year days, day total with minute-to-second scaling,
// multiply by 86400), each taking a new word every cycle unless stalled. Stages
// collapse bubbles, so a stall at the output holds the words in place without
// loss. Leap years are plain multiples of four, the seconds digits are ignored
// and the day of month counts from one.
module bcd_date_time_to_epoch_seconds_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [31:0]                    time_bcd,
    input  wire logic [31:0]                    date_bcd,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [bcdep_pkg::EPOCH_W-1:0]       epoch_seconds
);
    import bcdep_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 rdy1, rdy2, rdy3, rdy4;

    logic [YEAR_W-1:0]    year1_reg;
    logic [PART_W-1:0]    part1_reg;
    logic [TMIN_W-1:0]    tmin1_reg;
    logic [DAYS_W-1:0]    prior2_reg;
    logic [PART_W-1:0]    part2_reg;
    logic [TMIN_W-1:0]    tmin2_reg;
    logic [DAYS_W-1:0]    days3_reg;
    logic [TOD_W-1:0]     tod3_reg;
    logic [EPOCH_W-1:0]   epoch4_reg;

    logic [YEAR_W-1:0]    year1_next;
    logic [PART_W-1:0]    part1_next;
    logic [TMIN_W-1:0]    tmin1_next;
    logic [DAYS_W-1:0]    prior2_next;
    logic [DAYS_W-1:0]    days3_next;
    logic [TOD_W-1:0]     tod3_next;
    logic [EPOCH_W-1:0]   epoch4_next;

    logic [7:0]           day_b, mon_b, yr_b, cen_b, min_b, hr_b;
    logic [YEAR_W-1:0]    yr_m1;
    logic [DAYS_W-1:0]    day_sum;
    logic [DAYS_W+16:0]   day_secs;

    assign rdy4     = !v4_reg || out_ready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 1: decode, calendar year, days within the year, minutes of day
    always_comb
    begin
        day_b = bcd_val(date_bcd[7:0]);
        mon_b = bcd_val(date_bcd[15:8]);
        yr_b  = bcd_val(date_bcd[23:16]);
        cen_b = bcd_val(date_bcd[31:24]);
        min_b = bcd_val(time_bcd[15:8]);
        hr_b  = bcd_val(time_bcd[23:16]);
        year1_next = YEAR_W'(({7'd0, cen_b} << 6) + ({7'd0, cen_b} << 5)
                     + ({7'd0, cen_b} << 2) + {7'd0, yr_b});
        part1_next = {1'b0, day_b} + days_before_month(mon_b)
                     + {8'd0, (mon_b > 8'd2) && (yr_b[1:0] == 2'b00)};
        tmin1_next = TMIN_W'(({6'd0, hr_b} << 6) - ({6'd0, hr_b} << 2) + {6'd0, min_b});
    end

    // stage 2: days of the years since the epoch
    always_comb
    begin
        yr_m1 = year1_reg - YEAR_W'(1);
        if (year1_reg <= YEAR_W'(EPOCH_YEAR))
            prior2_next = '0;
        else
            prior2_next = DAYS_W'((year1_reg - YEAR_W'(EPOCH_YEAR)) * DAYS_W'(DAYS_PER_YR))
                          + DAYS_W'(yr_m1[YEAR_W-1:2]) - DAYS_W'(LEAP_BASE);
    end

    // stage 3: whole days, day of month counted from one, seconds of day
    always_comb
    begin
        day_sum    = prior2_reg + DAYS_W'(part2_reg);
        days3_next = (day_sum == '0) ? '0 : day_sum - DAYS_W'(1);
        tod3_next  = TOD_W'(({6'd0, tmin2_reg} << 6) - ({6'd0, tmin2_reg} << 2));
    end

    // stage 4: scale days to seconds and add the seconds of day
    always_comb
    begin
        day_secs    = {17'd0, days3_reg} * (DAYS_W+17)'(SECS_PER_DAY);
        epoch4_next = day_secs[EPOCH_W-1:0] + EPOCH_W'(tod3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            year1_reg <= year1_next;
            part1_reg <= part1_next;
            tmin1_reg <= tmin1_next;
        end
        if (rdy2)
        begin
            prior2_reg <= prior2_next;
            part2_reg  <= part1_reg;
            tmin2_reg  <= tmin1_reg;
        end
        if (rdy3)
        begin
            days3_reg <= days3_next;
            tod3_reg  <= tod3_next;
        end
        if (rdy4)
            epoch4_reg <= epoch4_next;
    end

    assign out_valid     = v4_reg;
    assign epoch_seconds = epoch4_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("accepted word did not enter stage 1");

    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !v4_reg |-> in_ready)
        else $error("input stalled with output stage empty");

    a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !rdy3) |=> (v2_reg && $stable(prior2_reg) && $stable(part2_reg)))
        else $error("stage 2 word changed while stalled");

    a_stage3_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rdy4) |=> v4_reg)
        else $error("stage 3 word lost on advance");

endmodule
`default_nettype wire
